// ----- design/adf_pkg.sv -----
package adf_pkg;

    // Fraction digits kept; further digits are dropped.
    localparam int MAX_FRAC = 9;

    localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Quotient bits resolved per divider cycle, and cycles per division.
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITERS = 32 / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic signed [63:0] value_q31_32;
        logic               overflow;
    } t_out;

    // One finished parse, handed from the parser to the divider.
    typedef struct packed {
        logic        negative;
        logic        saturated;
        logic [31:0] int_part;
        logic [29:0] frac_part;
        logic [3:0]  frac_digits;
    } t_job;

    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ----- design/adf_front.sv -----
module adf_front
    import adf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_item,
    output logic o_job_push,
    output t_job o_job
);

    localparam logic [1:0] PH_BLANK = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic        r_neg, n_neg;
    logic        r_sat, n_sat;
    logic [31:0] r_int, n_int;
    logic [29:0] r_frac, n_frac;
    logic [3:0]  r_dig, n_dig;

    logic [7:0]  ch;
    logic [7:0]  ch_off;
    logic [3:0]  digit;
    logic        is_digit, is_blank, is_point;
    logic [34:0] int_cand;

    assign ch       = i_item.char_code;
    assign ch_off   = ch - CH_ZERO;
    assign digit    = ch_off[3:0];
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_point = (ch == CH_POINT) || (ch == CH_COMMA);

    // acc * 10 + digit, wide enough to see the overflow
    assign int_cand = {r_int, 3'b000} + {2'b00, r_int, 1'b0} + {31'd0, digit};

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_sat   = r_sat;
        n_int   = r_int;
        n_frac  = r_frac;
        n_dig   = r_dig;
        unique case (r_phase)
            PH_BLANK: begin
                if (is_blank) begin
                    n_phase = PH_BLANK;
                end else if (ch == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_INT;
                end else if (ch == CH_PLUS) begin
                    n_phase = PH_INT;
                end else if (is_digit) begin
                    n_int   = int_cand[31:0];
                    n_phase = PH_INT;
                end else if (is_point) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    if (int_cand > {3'b000, INT_LIMIT}) begin
                        n_int = INT_LIMIT;
                        n_sat = 1'b1;
                    end else begin
                        n_int = int_cand[31:0];
                    end
                end else if (is_point) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    if (r_dig < 4'(MAX_FRAC)) begin
                        n_frac = 30'({r_frac, 3'b000} + {r_frac, 1'b0} + {26'd0, digit});
                        n_dig  = r_dig + 4'd1;
                    end
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // The first digit from blank phase cannot overflow, so no check is needed there.
    assign o_job_push        = i_accept && i_item.last_char;
    assign o_job.negative    = n_neg;
    assign o_job.saturated   = n_sat;
    assign o_job.int_part    = n_int;
    assign o_job.frac_part   = n_frac;
    assign o_job.frac_digits = n_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_job_push) begin
            r_phase <= PH_BLANK;
            r_neg   <= 1'b0;
            r_sat   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_dig   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_sat   <= n_sat;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_dig   <= n_dig;
        end
    end

    a_sat_holds_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_int == INT_LIMIT))
        else $error("saturated flag set without integer held at limit");

endmodule

// ----- design/adf_jobq.sv -----
module adf_jobq
    import adf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full |-> !i_push) and (o_empty |-> !i_pop))
        else $error("job queue pushed while full or popped while empty");

endmodule

// ----- design/adf_back.sv -----
module adf_back
    import adf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_empty,
    input  t_job i_job,
    output logic o_job_pop,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]           r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [29:0]          r_rem, n_rem;
    logic [31:0]          r_low, n_low;
    logic [29:0]          r_den;
    logic [31:0]          r_int;
    logic                 r_neg;
    logic                 r_sat;
    t_out                 r_out;
    logic                 r_out_vld;

    logic [29:0] den_load;
    logic [30:0] trial;
    logic [63:0] mag;
    logic        out_free;

    assign den_load  = pow10(i_job.frac_digits);
    assign o_job_pop = (r_state == ST_IDLE) && !i_job_empty;
    assign out_free  = !r_out_vld || i_pop;
    assign mag       = {r_int, r_low};
    assign o_empty   = !r_out_vld;
    assign o_result  = r_out;

    // Restoring division, DIV_STEP quotient bits per cycle. Quotient bits
    // shift into r_low as the numerator's low bits shift out.
    always_comb begin
        n_rem = r_rem;
        n_low = r_low;
        trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {n_rem, n_low[31]};
            n_low = {n_low[30:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem    = 30'(trial - {1'b0, r_den});
                n_low[0] = 1'b1;
            end else begin
                n_rem = trial[29:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // Load a finished result, else drop the one just popped.
            if ((r_state == ST_FIN) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_job_pop) begin
                        r_state <= ST_DIV;
                        r_cnt   <= '0;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: numerator is frac * 2^32 + den / 2; its top part is the
    // fraction itself, already below the divisor.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_rem <= i_job.frac_part;
            r_low <= {3'b000, den_load[29:1]};
            r_den <= den_load;
            r_int <= i_job.int_part;
            r_neg <= i_job.negative;
            r_sat <= i_job.saturated;
        end else if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
        if ((r_state == ST_FIN) && out_free) begin
            r_out.value_q31_32 <= r_neg ? $signed(64'd0 - mag) : $signed(mag);
            r_out.overflow     <= r_sat;
        end
    end

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_pop) |=> (r_out_vld && $stable(r_out)))
        else $error("waiting result lost or overwritten");

endmodule

// ----- design/ascii_decimal_to_fixed.sv -----
// Decimal text to Q31.32: one character per cycle, full stalls only while the job queue is full.
// Result path: job queue, then divider states ST_DIV and ST_FIN, then the result register.
// The parser takes new strings while the radix-16 divider works one job, until the queue is full.
// Reset: synchronous, active low; clears parser state, job queue and the result register.
module ascii_decimal_to_fixed
    import adf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic in_xfer;
    logic job_push;
    t_job job_in;
    logic jobq_full;
    logic jobq_empty;
    logic job_pop;
    t_job job_out;

    // Hold input while the queue cannot take a finished parse.
    assign full    = jobq_full;
    assign in_xfer = push && !jobq_full;

    // Front end: classify each character and accumulate integer and fraction digits.
    adf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_xfer),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // Two-entry queue decouples the parser from the divider.
    adf_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (jobq_full),
        .i_pop   (job_pop),
        .o_empty (jobq_empty),
        .o_job   (job_out)
    );

    // Back end: scale the fraction by 2^32 / 10^digits, apply sign, register result.
    adf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (jobq_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
